### rtl/core/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared widths and constants for the Q16.16 vector normalizer.
// ----------------------------------------------------------------------------
package vnorm_pkg;

    localparam int WORD_W      = 32;
    localparam int MAG_W       = 24;
    localparam int GUARD_SHIFT = 14;

    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MAG_W-1:0]  mag_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } vec_t;

endpackage

### rtl/core/vector3_normalize_q16_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_q16_core
// Fixed-point 3-vector normalization: magnitude and unit vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock while the output is not stalled. The
// stages are the two square stages, one stage per root bit and one per quotient
// bit plus the divider's setup and output stages. The whole pipeline advances
// together; it holds only when a result sits at the output and out_ready is
// low. A zero vector returns 0x7FFFFFFF in every unit field.
module vector3_normalize_q16_core
    import vnorm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] unit_x,
    output logic signed [31:0] unit_y,
    output logic signed [31:0] unit_z,
    output logic        [23:0] magnitude
);

    localparam int DIV_LAT = GUARD_SHIFT + FRAC_BITS + 2;

    logic  en;
    vec_t  in_vec;
    logic  sq_valid;
    vec_t  sq_vec;
    word_t sq_sum;
    logic  rt_valid;
    vec_t  rt_vec;
    mag_t  rt_root;
    logic  dx_valid;
    logic  dy_valid;
    logic  dz_valid;
    word_t qx;
    word_t qy;
    word_t qz;
    mag_t  mag_reg [1:DIV_LAT];

    assign en       = out_ready | ~dx_valid;
    assign in_ready = en;
    assign in_vec   = '{x: word_t'(vec_x), y: word_t'(vec_y), z: word_t'(vec_z)};

    vnorm_square #(.FRAC_BITS(FRAC_BITS)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_vec    (in_vec),
        .out_valid (sq_valid),
        .out_vec   (sq_vec),
        .out_sum   (sq_sum)
    );

    vnorm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_vec    (sq_vec),
        .in_sum    (sq_sum),
        .out_valid (rt_valid),
        .out_vec   (rt_vec),
        .out_root  (rt_root)
    );

    vnorm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in_a      (rt_vec.x),
        .in_b      (rt_root),
        .out_valid (dx_valid),
        .out_q     (qx)
    );

    vnorm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in_a      (rt_vec.y),
        .in_b      (rt_root),
        .out_valid (dy_valid),
        .out_q     (qy)
    );

    vnorm_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt_valid),
        .in_a      (rt_vec.z),
        .in_b      (rt_root),
        .out_valid (dz_valid),
        .out_q     (qz)
    );

    // hold the magnitude alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[1] <= rt_root;
            for (int i = 2; i <= DIV_LAT; i++)
            begin
                mag_reg[i] <= mag_reg[i-1];
            end
        end
    end

    assign out_valid = dx_valid & dy_valid & dz_valid;
    assign unit_x    = qx;
    assign unit_y    = qy;
    assign unit_z    = qz;
    assign magnitude = mag_reg[DIV_LAT];

endmodule

### rtl/core/vnorm_square.sv
// ----------------------------------------------------------------------------
// vnorm_square
// Two stages: fixed-point squares of the three components, then their sum.
// ----------------------------------------------------------------------------
module vnorm_square
    import vnorm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  vec_t  in_vec,
    output logic  out_valid,
    output vec_t  out_vec,
    output word_t out_sum
);

    logic                  v1_reg;
    logic                  v2_reg;
    logic [2*WORD_W-1:0]   px_reg;
    logic [2*WORD_W-1:0]   py_reg;
    logic [2*WORD_W-1:0]   pz_reg;
    vec_t                  vec1_reg;
    vec_t                  vec2_reg;
    word_t                 sum_reg;
    word_t                 ax;
    word_t                 ay;
    word_t                 az;
    word_t                 sum_next;

    assign ax = in_vec.x[WORD_W-1] ? (~in_vec.x + 1'b1) : in_vec.x;
    assign ay = in_vec.y[WORD_W-1] ? (~in_vec.y + 1'b1) : in_vec.y;
    assign az = in_vec.z[WORD_W-1] ? (~in_vec.z + 1'b1) : in_vec.z;

    assign sum_next = px_reg[FRAC_BITS +: WORD_W] + py_reg[FRAC_BITS +: WORD_W]
                    + pz_reg[FRAC_BITS +: WORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= 64'(ax) * 64'(ax);
            py_reg   <= 64'(ay) * 64'(ay);
            pz_reg   <= 64'(az) * 64'(az);
            vec1_reg <= in_vec;
            sum_reg  <= sum_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec2_reg;
    assign out_sum   = sum_reg;

endmodule

### rtl/core/vnorm_sqrt.sv
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Restoring square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module vnorm_sqrt
    import vnorm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  vec_t  in_vec,
    input  word_t in_sum,
    output logic  out_valid,
    output vec_t  out_vec,
    output mag_t  out_root
);

    localparam int S  = 16 + FRAC_BITS / 2;
    localparam int RW = S + 3;

    logic          val_reg  [1:S];
    logic [RW-1:0] rem_reg  [1:S];
    logic [S-1:0]  root_reg [1:S];
    word_t         lo_reg   [1:S];
    vec_t          vec_reg  [1:S];

    for (genvar i = 0; i < S; i++)
    begin : g_step
        logic          val_src;
        logic [RW-1:0] rem_src;
        logic [S-1:0]  root_src;
        word_t         lo_src;
        vec_t          vec_src;
        logic [RW-1:0] shifted;
        logic [S-1:0]  root_sh;
        logic [RW-1:0] trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign val_src  = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign lo_src   = in_sum;
            assign vec_src  = in_vec;
        end
        else
        begin : g_mid
            assign val_src  = val_reg[i];
            assign rem_src  = rem_reg[i];
            assign root_src = root_reg[i];
            assign lo_src   = lo_reg[i];
            assign vec_src  = vec_reg[i];
        end

        assign shifted = {rem_src[RW-3:0], lo_src[WORD_W-1 -: 2]};
        assign root_sh = {root_src[S-2:0], 1'b0};
        assign trial   = RW'({root_sh, 1'b1});
        assign ge      = shifted >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[i+1] <= val_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? (shifted - trial) : shifted;
                root_reg[i+1] <= {root_sh[S-1:1], ge};
                lo_reg[i+1]   <= {lo_src[WORD_W-3:0], 2'b00};
                vec_reg[i+1]  <= vec_src;
            end
        end
    end

    assign out_valid = val_reg[S];
    assign out_vec   = vec_reg[S];
    assign out_root  = MAG_W'(root_reg[S]);

endmodule

### rtl/core/vnorm_div.sv
// ----------------------------------------------------------------------------
// vnorm_div
// Saturating signed fixed-point divide by the magnitude, one quotient bit
// per pipeline stage.
// ----------------------------------------------------------------------------
module vnorm_div
    import vnorm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  word_t in_a,
    input  mag_t  in_b,
    output logic  out_valid,
    output word_t out_q
);

    localparam int QW = GUARD_SHIFT + FRAC_BITS;
    localparam int RW = MAG_W + 1;

    word_t          mag_a;
    logic           sat_pre;
    logic           val_reg  [0:QW];
    logic           neg_reg  [0:QW];
    logic           sat_reg  [0:QW];
    mag_t           b_reg    [0:QW];
    logic [RW-1:0]  r_reg    [0:QW];
    logic [QW-1:0]  lo_reg   [0:QW];
    logic [QW-1:0]  q_reg    [0:QW];
    logic           out_valid_reg;
    word_t          out_q_reg;
    word_t          q_ext;
    word_t          q_next;

    assign mag_a   = in_a[WORD_W-1] ? (~in_a + 1'b1) : in_a;
    assign sat_pre = (mag_a >> GUARD_SHIFT) >= WORD_W'(in_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= in_a[WORD_W-1];
            sat_reg[0] <= sat_pre;
            b_reg[0]   <= in_b;
            r_reg[0]   <= RW'(mag_a >> GUARD_SHIFT);
            lo_reg[0]  <= {mag_a[GUARD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
            q_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [RW-1:0] t;
        logic          ge;

        assign t  = {r_reg[i][RW-2:0], lo_reg[i][QW-1]};
        assign ge = t >= RW'(b_reg[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[i+1] <= val_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
                b_reg[i+1]   <= b_reg[i];
                r_reg[i+1]   <= ge ? (t - RW'(b_reg[i])) : t;
                lo_reg[i+1]  <= {lo_reg[i][QW-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][QW-2:0], ge};
            end
        end
    end

    assign q_ext = WORD_W'(q_reg[QW]);

    always_comb
    begin
        if (sat_reg[QW])
        begin
            q_next = neg_reg[QW] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            q_next = neg_reg[QW] ? (~q_ext + 1'b1) : q_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= val_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_q_reg <= q_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_q     = out_q_reg;

endmodule

### verif/tb_vector3_normalize_q16_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_q16_core
// Drives vectors through the normalizer with random gaps on both sides and
// checks magnitude and unit vector against a bit-exact Q16.16 predictor.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_q16_core
    import vnorm_pkg::*;
();

    localparam int FRAC     = 16;
    localparam int ROOT_N   = 16 + FRAC / 2;
    localparam int LATENCY  = 2 + ROOT_N + 16 + FRAC;
    localparam int N_RANDOM = 900;

    typedef struct {
        word_t x;
        word_t y;
        word_t z;
    } vec_req_t;

    typedef struct {
        word_t ux;
        word_t uy;
        word_t uz;
        mag_t  mag;
    } norm_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] unit_x;
    logic [31:0] unit_y;
    logic [31:0] unit_z;
    logic [23:0] magnitude;

    vec_req_t  pending_reqs[$];
    norm_res_t expected_norms[$];
    int        errors;
    int        n_checked;
    int        n_sat;
    bit        stim_done;
    int        send_wait;
    int        recv_wait;

    vector3_normalize_q16_core #(.FRAC_BITS(FRAC)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .magnitude (magnitude)
    );

    function automatic word_t square_q(word_t v);
        logic [63:0] m;
        logic [63:0] p;
        m = v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
        if (v == 32'h8000_0000)
            m = 64'h8000_0000;
        p = (m * m) >> FRAC;
        return p[31:0];
    endfunction

    function automatic mag_t root_q(word_t s);
        logic [63:0] root;
        logic [63:0] rem;
        logic [31:0] lo;
        logic [63:0] trial;
        root = 0;
        rem = 0;
        lo = s;
        for (int i = 0; i < ROOT_N; i++)
        begin
            rem = (rem << 2) | lo[31:30];
            lo = lo << 2;
            root = root << 1;
            trial = (root << 1) + 1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = root + 1;
            end
        end
        return root[23:0];
    endfunction

    function automatic word_t divide_q(word_t a, mag_t b);
        logic [63:0] am;
        logic [63:0] q;
        am = a[31] ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
        if ((am >> GUARD_SHIFT) >= {40'd0, b} || b == 0)
            return a[31] ? SAT_NEG : SAT_POS;
        q = (am << FRAC) / {40'd0, b};
        if (a[31])
            q = 64'h1_0000_0000 - q;
        return q[31:0];
    endfunction

    function automatic norm_res_t normalize(vec_req_t v);
        norm_res_t r;
        word_t     sum;
        sum = square_q(v.x) + square_q(v.y) + square_q(v.z);
        r.mag = root_q(sum);
        r.ux = divide_q(v.x, r.mag);
        r.uy = divide_q(v.y, r.mag);
        r.uz = divide_q(v.z, r.mag);
        return r;
    endfunction

    function automatic word_t rand_comp(int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            3: return $urandom_range(0, 32'h00B4_0000) - 32'h005A_0000;
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    task automatic add_req(word_t x, word_t y, word_t z);
        vec_req_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        pending_reqs.push_back(v);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        int kind;
        rst_n = 1'b0;
        add_req(0, 0, 0);
        add_req(32'h0001_0000, 0, 0);
        add_req(0, 32'hFFFF_0000, 0);
        add_req(0, 0, 32'h0000_0001);
        add_req(32'h8000_0000, 0, 0);
        add_req(32'h7FFF_FFFF, 0, 0);
        add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'h0003_0000, 32'h0004_0000, 0);
        add_req(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
        add_req(32'h00B5_04F3, 0, 0);
        add_req(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0100);
        add_req(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        add_req(1, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 4);
            add_req(rand_comp(kind), rand_comp(kind), rand_comp($urandom_range(0, 4)));
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            vec_x <= '0;
            vec_y <= '0;
            vec_z <= '0;
            send_wait <= 0;
            stim_done <= 1'b0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold
        end
        else if (send_wait > 0)
        begin
            in_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            vec_req_t v;
            v = pending_reqs.pop_front();
            expected_norms.push_back(normalize(v));
            in_valid <= 1'b1;
            vec_x <= v.x;
            vec_y <= v.y;
            vec_z <= v.z;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end
        else
        begin
            in_valid <= 1'b0;
            stim_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            errors = 0;
            n_checked = 0;
            n_sat = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                norm_res_t e;
                if (expected_norms.size() == 0)
                begin
                    $error("result with no request pending");
                    errors++;
                end
                else
                begin
                    e = expected_norms.pop_front();
                    n_checked++;
                    if (e.ux == SAT_POS || e.ux == SAT_NEG)
                        n_sat++;
                    if (unit_x !== e.ux)
                    begin
                        $error("unit_x expected %h actual %h", e.ux, unit_x);
                        errors++;
                    end
                    if (unit_y !== e.uy)
                    begin
                        $error("unit_y expected %h actual %h", e.uy, unit_y);
                        errors++;
                    end
                    if (unit_z !== e.uz)
                    begin
                        $error("unit_z expected %h actual %h", e.uz, unit_z);
                        errors++;
                    end
                    if (magnitude !== e.mag)
                    begin
                        $error("magnitude expected %h actual %h", e.mag, magnitude);
                        errors++;
                    end
                end
            end
            if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done && expected_norms.size() == 0);
        repeat (LATENCY * 2) @(posedge clk);
        $display("Checked %0d normalized vectors, %0d with a saturated x component.",
                 n_checked, n_sat);
        if (errors == 0 && expected_norms.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule
